### rtl/core/tlbf_pkg.sv
package tlbf_pkg;

    // default geometry of the bitmap
    localparam int ITEM_COUNT_DEF = 4096;
    localparam int WORD_BITS_DEF  = 64;

    // field widths on the stream ports
    localparam int CMD_W      = 3;
    localparam int IDX_W      = 12;
    localparam int WIDX_W     = 6;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // most words a single list command may name
    localparam int LIST_MAX   = 64;

    // shift of the reciprocal division of an item index by the word width,
    // exact for any word width up to 64 with a 12-bit index
    localparam int DIV_SHIFT  = IDX_W + 6;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_CHECK  = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_EMPTY  = 3'd3,
        CMD_LIST   = 3'd4
    } cmd_t;

endpackage

### rtl/core/tlbf_ram.sv
module tlbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/two_level_bitmap_frontier_unit.sv
// Two-level bitmap frontier for graph search.
// Input channel s_: one command per transfer (insert, check, clear, empty
// query, list active words) with an item index. Result channel m_: one
// result per command, except the first list after a clear or reset that
// finds active words, which gives one result per active word (at most
// LIST_MAX) in ascending order with m_tlast on the final one. Item bits
// sit in a word memory with a registered read; a summary register holds
// one bit per word and marks the words holding valid data, so a clear
// only wipes the summary. The idle step takes a command, divides the
// index and reads the word; the execute step checks or writes it back
// and loads the output register. An insert is a read-modify-write of one
// memory word, and the next command is only taken once the write has
// landed, so no forwarding is needed. A list then walks the summary bits
// one word per cycle, pausing on an active word while the output is busy.
// A result waiting in the output register does not block the next input
// transfer; a stalled receiver holds the block in its result step.
// After reset (aresetn low at a clock edge) the bitmap is empty and the
// block is ready; no clearing pass is needed.
module two_level_bitmap_frontier_unit
    import tlbf_pkg::*;
#(
    parameter int ITEM_COUNT = ITEM_COUNT_DEF,
    parameter int WORD_BITS  = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input transfers
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] item_index
    input  logic [CMD_W-1:0]     s_tuser,   // [2:0] command
    // result transfers
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [0] bit_is_set, [1] is_empty,
                                            // [7:2] word_index, [8] word_valid,
                                            // [9] out_of_range
    output logic                 m_tlast
);

    localparam int WORD_COUNT = (ITEM_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int WORD_SLOTS = 1 << AW;
    localparam int BW         = $clog2(WORD_BITS);
    localparam int RECIP      = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int PROD_W     = IDX_W + RECIP_W;
    localparam int Q_W        = PROD_W - DIV_SHIFT;
    localparam int CNT_W      = $clog2(WORD_SLOTS + 1);
    localparam int EMIT_W     = $clog2(LIST_MAX + 1);
    localparam int TGT_W      = (CNT_W > EMIT_W) ? CNT_W : EMIT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LIST
    } state_t;

    state_t                state_reg, state_next;
    logic [CMD_W-1:0]      cmd_reg, cmd_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [Q_W-1:0]        word_reg, word_next;
    logic                  oor_reg, oor_next;
    logic [WORD_SLOTS-1:0] summary_reg, summary_next;
    logic [CNT_W-1:0]      set_count_reg, set_count_next;
    logic                  list_done_reg, list_done_next;
    logic [AW-1:0]         ptr_reg, ptr_next;
    logic [EMIT_W-1:0]     emit_cnt_reg, emit_cnt_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  bit_set_reg, bit_set_next;
    logic                  empty_reg, empty_next;
    logic [WIDX_W-1:0]     widx_reg, widx_next;
    logic                  wvalid_reg, wvalid_next;
    logic                  last_reg, last_next;
    logic                  oor_out_reg, oor_out_next;

    // memory signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    // input side decode
    logic                  s_xfer;
    logic [IDX_W-1:0]      s_idx;
    logic [PROD_W-1:0]     div_prod;
    logic [Q_W-1:0]        s_word;
    logic                  s_oor;

    // execute side decode
    logic                  out_free;
    logic [IDX_W-1:0]      bit_off_full;
    logic [BW-1:0]         bit_off;
    logic                  word_live;
    logic [WORD_BITS-1:0]  cur_word;
    logic [TGT_W-1:0]      list_target;
    logic [TGT_W-1:0]      emit_plus;
    logic                  emit_last;
    logic [IDX_W-1:0]      ptr_ext;

    assign s_xfer   = s_tvalid && s_tready;
    assign s_idx    = s_tdata[IDX_W-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // word index by reciprocal multiplication, exact for 12-bit indices
    assign div_prod = PROD_W'(s_idx) * PROD_W'(RECIP);
    assign s_word   = div_prod[PROD_W-1:DIV_SHIFT];
    assign s_oor    = 32'(s_idx) >= 32'(ITEM_COUNT);

    // read the incoming word when idle, keep re-reading the held word while
    // the result step waits for the receiver
    assign ram_raddr = (state_reg == ST_IDLE) ? (s_oor ? '0 : s_word[AW-1:0])
                                              : (oor_reg ? '0 : word_reg[AW-1:0]);

    // bit position inside the word
    assign bit_off_full = idx_reg - IDX_W'(32'(word_reg) * WORD_BITS);
    assign bit_off      = bit_off_full[BW-1:0];

    // a word without its summary bit has not been written since the last clear
    assign word_live = summary_reg[word_reg[AW-1:0]];
    assign cur_word  = word_live ? ram_rdata : '0;

    // list bookkeeping
    assign list_target = (32'(set_count_reg) >= LIST_MAX) ? TGT_W'(LIST_MAX)
                                                          : TGT_W'(set_count_reg);
    assign emit_plus   = TGT_W'(emit_cnt_reg) + TGT_W'(1);
    assign emit_last   = (emit_plus == list_target);
    assign ptr_ext     = IDX_W'(ptr_reg);

    tlbf_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next-state logic
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        oor_next       = oor_reg;
        summary_next   = summary_reg;
        set_count_next = set_count_reg;
        list_done_next = list_done_reg;
        ptr_next       = ptr_reg;
        emit_cnt_next  = emit_cnt_reg;

        m_tvalid_next  = m_tvalid_reg && !m_tready;
        bit_set_next   = bit_set_reg;
        empty_next     = empty_reg;
        widx_next      = widx_reg;
        wvalid_next    = wvalid_reg;
        last_next      = last_reg;
        oor_out_next   = oor_out_reg;

        ram_we         = 1'b0;
        ram_waddr      = word_reg[AW-1:0];
        ram_wdata      = cur_word | (WORD_BITS'(1) << bit_off);

        unique case (state_reg)
            ST_IDLE: begin
                // take a command and start the word read
                if (s_xfer) begin
                    cmd_next   = s_tuser;
                    idx_next   = s_idx;
                    word_next  = s_word;
                    oor_next   = s_oor;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    // default single result
                    m_tvalid_next = 1'b1;
                    bit_set_next  = 1'b0;
                    empty_next    = 1'b0;
                    widx_next     = '0;
                    wvalid_next   = 1'b0;
                    last_next     = 1'b1;
                    oor_out_next  = 1'b0;
                    state_next    = ST_IDLE;

                    priority case (cmd_reg)
                        CMD_INSERT: begin
                            oor_out_next = oor_reg;
                            if (!oor_reg) begin
                                ram_we = 1'b1;
                                summary_next[word_reg[AW-1:0]] = 1'b1;
                                if (!word_live) begin
                                    set_count_next = set_count_reg + CNT_W'(1);
                                end
                            end
                        end
                        CMD_CHECK: begin
                            oor_out_next = oor_reg;
                            bit_set_next = !oor_reg && cur_word[bit_off];
                        end
                        CMD_CLEAR: begin
                            summary_next   = '0;
                            set_count_next = '0;
                            list_done_next = 1'b0;
                        end
                        CMD_EMPTY: begin
                            empty_next = (summary_reg == '0);
                        end
                        CMD_LIST: begin
                            // walk only on the first list with active words
                            if (!list_done_reg && set_count_reg != '0) begin
                                m_tvalid_next = m_tvalid_reg && !m_tready;
                                ptr_next      = '0;
                                emit_cnt_next = '0;
                                state_next    = ST_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_LIST: begin
                // one summary bit per cycle, stall on a set bit while output busy
                if (summary_reg[ptr_reg]) begin
                    if (out_free) begin
                        m_tvalid_next = 1'b1;
                        bit_set_next  = 1'b0;
                        empty_next    = 1'b0;
                        widx_next     = ptr_ext[WIDX_W-1:0];
                        wvalid_next   = 1'b1;
                        last_next     = emit_last;
                        oor_out_next  = 1'b0;
                        emit_cnt_next = emit_cnt_reg + EMIT_W'(1);
                        ptr_next      = ptr_reg + AW'(1);
                        if (emit_last) begin
                            list_done_next = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            summary_reg   <= '0;
            set_count_reg <= '0;
            list_done_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            summary_reg   <= summary_next;
            set_count_reg <= set_count_next;
            list_done_reg <= list_done_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        word_reg     <= word_next;
        oor_reg      <= oor_next;
        ptr_reg      <= ptr_next;
        emit_cnt_reg <= emit_cnt_next;
        bit_set_reg  <= bit_set_next;
        empty_reg    <= empty_next;
        widx_reg     <= widx_next;
        wvalid_reg   <= wvalid_next;
        last_reg     <= last_next;
        oor_out_reg  <= oor_out_next;
    end

    // output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = M_TDATA_W'({oor_out_reg, wvalid_reg, widx_reg, empty_reg, bit_set_reg});

    // summary population counter tracks the summary register
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(set_count_reg) == $countones(summary_reg))
        else $error("set word count out of step with summary bits");

    // memory is written only by an in-range insert being executed
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_EXEC && cmd_reg == CMD_INSERT && !oor_reg))
        else $error("word memory written outside an insert");

    // summary slots past the last word never become set
    a_no_ghost_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (summary_reg >> WORD_COUNT) == '0)
        else $error("summary bit set beyond word count");

    // listing never emits more than the limit
    a_list_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LIST |-> 32'(emit_cnt_reg) < LIST_MAX)
        else $error("list emitted beyond its limit");

    // final listed word marks the list as done
    a_list_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST && summary_reg[ptr_reg] && out_free && emit_last)
        |=> list_done_reg)
        else $error("list finished without marking done");

endmodule

### tb/two_level_bitmap_frontier_unit_tb.sv
module two_level_bitmap_frontier_unit_tb;
    import tlbf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT    = ITEM_COUNT_DEF;
    localparam int WORD_BITS     = WORD_BITS_DEF;
    localparam int WORD_COUNT    = (ITEM_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int RANDOM_ITEMS  = 135;
    localparam int HOLD_AT       = 30;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 200000;

    // command codes that the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_SPARSE
    } ready_mode_t;

    typedef struct packed {
        logic              bit_is_set;
        logic              is_empty;
        logic [WIDX_W-1:0] word_index;
        logic              word_valid;
        logic              last;
        logic              out_of_range;
    } frontier_result_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        int               gap;
        bit               drain;
    } frontier_cmd_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // shadow copy of the bitmap
    logic [WORD_BITS-1:0]  word_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] summary_mask = '0;
    bit                    listed = 1'b0;

    frontier_cmd_t    cmd_q[$];
    frontier_result_t result_q[$];

    int  err_count      = 0;
    int  cycle_count    = 0;
    int  accepted_count = 0;
    int  result_seq     = 0;
    bit  in_xfer        = 1'b0;
    int  burst_left     = 0;

    two_level_bitmap_frontier_unit #(
        .ITEM_COUNT(ITEM_COUNT),
        .WORD_BITS (WORD_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int seq, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s got %0h want %0h", seq, name, got, want));
        end
    endtask

    // work out the results of one accepted command and update the shadow bitmap
    task automatic frontier_predict(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
        frontier_result_t r;
        int  w;
        int  b;
        int  words[$];
        bit  oor;
        r = '0;
        r.last = 1'b1;
        oor = int'(idx) >= ITEM_COUNT;
        w = int'(idx) / WORD_BITS;
        b = int'(idx) % WORD_BITS;
        case (cmd)
            CMD_INSERT: begin
                if (!oor) begin
                    word_mem[w][b] = 1'b1;
                    summary_mask[w] = 1'b1;
                end
                r.out_of_range = oor;
                result_q.push_back(r);
            end
            CMD_CHECK: begin
                if (!oor) begin
                    r.bit_is_set = word_mem[w][b];
                end
                r.out_of_range = oor;
                result_q.push_back(r);
            end
            CMD_CLEAR: begin
                foreach (word_mem[i]) word_mem[i] = '0;
                summary_mask = '0;
                listed = 1'b0;
                result_q.push_back(r);
            end
            CMD_EMPTY: begin
                r.is_empty = (summary_mask == '0);
                result_q.push_back(r);
            end
            CMD_LIST: begin
                // a list names each active word once per clear, lowest first
                if (!listed) begin
                    for (int i = 0; i < WORD_COUNT && words.size() < LIST_MAX; i++) begin
                        if (summary_mask[i]) words.push_back(i);
                    end
                end
                if (words.size() == 0) begin
                    result_q.push_back(r);
                end else begin
                    listed = 1'b1;
                    foreach (words[k]) begin
                        r = '0;
                        r.word_index = WIDX_W'(words[k]);
                        r.word_valid = 1'b1;
                        r.last = (k == words.size() - 1);
                        result_q.push_back(r);
                    end
                end
            end
            default: begin
                result_q.push_back(r);
            end
        endcase
    endtask

    // queue a command, sender bursts of random length with random gaps
    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int idx, input bit drain);
        frontier_cmd_t c;
        c.cmd = cmd;
        c.idx = IDX_W'(idx);
        c.drain = drain;
        c.gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            c.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        cmd_q.push_back(c);
    endtask

    // transfer accounting and shadow update at the rising edge
    always @(posedge aclk) begin
        in_xfer <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            frontier_predict(s_tuser, s_tdata[IDX_W-1:0]);
            accepted_count++;
        end
    end

    // input driver
    always @(negedge aclk) begin
        static int  gap_left = 0;
        static bit  head_armed = 1'b0;
        logic       nxt_valid;
        if (aresetn && (!s_tvalid || in_xfer)) begin
            nxt_valid = 1'b0;
            if (cmd_q.size() > 0) begin
                if (!head_armed) begin
                    gap_left = cmd_q[0].gap;
                    head_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(cmd_q[0].drain && result_q.size() > 0)) begin
                    nxt_valid = 1'b1;
                    s_tdata <= S_TDATA_W'(cmd_q[0].idx);
                    s_tuser <= cmd_q[0].cmd;
                    void'(cmd_q.pop_front());
                    head_armed = 1'b0;
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge aclk) begin
        static int          hold_left  = 0;
        static bit          hold_done  = 1'b0;
        static int          phase_left = 0;
        static int          pat_cnt    = 0;
        static ready_mode_t mode       = READY_ALWAYS;
        logic               rdy;
        rdy = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && accepted_count >= HOLD_AT) begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rdy = 1'b0;
        end else begin
            if (phase_left == 0) begin
                mode = ready_mode_t'($urandom_range(0, 3));
                phase_left = $urandom_range(20, 120);
            end
            phase_left--;
            pat_cnt++;
            case (mode)
                READY_ALWAYS:   rdy = 1'b1;
                READY_COIN:     rdy = 1'($urandom_range(0, 1));
                READY_PERIODIC: rdy = (pat_cnt % 5) < 3;
                default:        rdy = ($urandom_range(0, 3) == 0);
            endcase
        end
        m_tready <= rdy;
    end

    // result monitor
    always @(posedge aclk) begin
        frontier_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result, m_tdata %0h", m_tdata));
            end else begin
                want = result_q.pop_front();
                check_field("bit_is_set", result_seq, 8'(m_tdata[0]), 8'(want.bit_is_set));
                check_field("is_empty", result_seq, 8'(m_tdata[1]), 8'(want.is_empty));
                check_field("word_index", result_seq, 8'(m_tdata[7:2]), 8'(want.word_index));
                check_field("word_valid", result_seq, 8'(m_tdata[8]), 8'(want.word_valid));
                check_field("out_of_range", result_seq, 8'(m_tdata[9]),
                            8'(want.out_of_range));
                check_field("last", result_seq, 8'(m_tlast), 8'(want.last));
            end
            result_seq++;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int rand_items;
        int hot[4];
        int n_hot;
        int n;
        int w;

        foreach (word_mem[i]) word_mem[i] = '0;

        // directed: empty bitmap, index extremes, repeated list, spare codes
        push_cmd(CMD_EMPTY, 0, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);
        push_cmd(CMD_CHECK, 0, 1'b0);
        push_cmd(CMD_INSERT, 0, 1'b0);
        push_cmd(CMD_INSERT, ITEM_COUNT - 1, 1'b0);
        push_cmd(CMD_INSERT, 5 * WORD_BITS + 3, 1'b0);
        push_cmd(CMD_INSERT, 5 * WORD_BITS + 3, 1'b0);
        push_cmd(CMD_CHECK, 0, 1'b0);
        push_cmd(CMD_CHECK, ITEM_COUNT - 1, 1'b0);
        push_cmd(CMD_CHECK, 1, 1'b0);
        push_cmd(CMD_CHECK, 5 * WORD_BITS + 2, 1'b0);
        push_cmd(CMD_EMPTY, 0, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);
        // an insert after a list does not rearm it
        push_cmd(CMD_INSERT, 100, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
            push_cmd(CMD_W'(c), $urandom_range(0, (1 << IDX_W) - 1), 1'b0);
        end
        push_cmd(CMD_CLEAR, 0, 1'b1);
        push_cmd(CMD_EMPTY, 0, 1'b0);
        push_cmd(CMD_CHECK, ITEM_COUNT - 1, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);
        push_cmd(CMD_INSERT, 7 * WORD_BITS, 1'b0);
        push_cmd(CMD_LIST, 0, 1'b0);

        // every word active, giving the longest list
        rand_items = 0;
        push_cmd(CMD_CLEAR, 0, 1'b0);
        for (int i = 0; i < WORD_COUNT; i++) begin
            push_cmd(CMD_INSERT, i * WORD_BITS + $urandom_range(0, WORD_BITS - 1), 1'b0);
        end
        push_cmd(CMD_LIST, 0, 1'b0);
        rand_items += WORD_COUNT + 2;

        // rounds of clear, inserts, checks and listing, mixed with noise
        while (rand_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    push_cmd(CMD_W'($urandom_range(0, CMD_SPARE_LAST)),
                             $urandom_range(0, (1 << IDX_W) - 1), 1'b0);
                end
                rand_items += n;
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    push_cmd(CMD_CLEAR, 0, $urandom_range(0, 3) == 0);
                    rand_items++;
                end
                n_hot = $urandom_range(1, 4);
                for (int i = 0; i < n_hot; i++) hot[i] = $urandom_range(0, WORD_COUNT - 1);
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        push_cmd(CMD_INSERT, $urandom_range(0, (1 << IDX_W) - 1), 1'b0);
                    end else begin
                        w = hot[$urandom_range(0, n_hot - 1)];
                        push_cmd(CMD_INSERT, w * WORD_BITS + $urandom_range(0, WORD_BITS - 1),
                                 1'b0);
                    end
                end
                rand_items += n;
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    w = hot[$urandom_range(0, n_hot - 1)];
                    push_cmd(CMD_CHECK, w * WORD_BITS + $urandom_range(0, WORD_BITS - 1), 1'b0);
                end
                rand_items += n;
                push_cmd(CMD_EMPTY, 0, 1'b0);
                push_cmd(CMD_LIST, 0, 1'b0);
                rand_items += 2;
                if ($urandom_range(0, 1) == 1) begin
                    if ($urandom_range(0, 1) == 1) begin
                        push_cmd(CMD_INSERT, $urandom_range(0, (1 << IDX_W) - 1), 1'b0);
                        rand_items++;
                    end
                    push_cmd(CMD_LIST, 0, 1'b0);
                    rand_items++;
                end
            end
        end

        // reset
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // wait for the stimulus to drain and the results to come back
        while (!(cmd_q.size() == 0 && !s_tvalid && result_q.size() == 0)) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        foreach (result_q[i]) begin
            report_mismatch($sformatf("expected result %0d never arrived", i));
        end

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
